FILE: rtl/core/bdfc_pkg.sv
// Package with the shared types and constants of the bulk dump frame checker.
package bdfc_pkg;

	localparam int unsigned RegWidth   = 7;
	localparam int unsigned ByteWidth  = 8;
	localparam int unsigned IndexWidth = 14;
	localparam int unsigned CountWidth = 15;
	localparam int unsigned CfgAddrWidth = 2;

	localparam logic [CountWidth-1:0] CountMax = '1;

	localparam logic [RegWidth-1:0] ManufacturerIdReset = 7'h43;
	localparam logic [RegWidth-1:0] GroupHighReset      = 7'h7f;
	localparam logic [RegWidth-1:0] GroupLowReset       = 7'h1c;
	localparam logic [RegWidth-1:0] ModelIdReset        = 7'h05;

	localparam logic [CountWidth-1:0] PosManufacturer = 15'd0;
	localparam logic [CountWidth-1:0] PosGroupHigh    = 15'd2;
	localparam logic [CountWidth-1:0] PosGroupLow     = 15'd3;
	localparam logic [CountWidth-1:0] PosLengthHigh   = 15'd4;
	localparam logic [CountWidth-1:0] PosLengthLow    = 15'd5;
	localparam logic [CountWidth-1:0] PosModel        = 15'd6;
	localparam logic [CountWidth-1:0] PosAddrHigh     = 15'd7;
	localparam logic [CountWidth-1:0] PosAddrMid      = 15'd8;
	localparam logic [CountWidth-1:0] PosAddrLow      = 15'd9;
	localparam logic [CountWidth-1:0] PosPayload      = 15'd10;
	localparam logic [CountWidth-1:0] HeaderBytes     = 15'd6;

	typedef enum logic [CfgAddrWidth-1:0] {
		REG_MANUFACTURER_ID = 2'd0,
		REG_GROUP_HIGH      = 2'd1,
		REG_GROUP_LOW       = 2'd2,
		REG_MODEL_ID        = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_FOREIGN  = 2'd1,
		STATUS_LENGTH   = 2'd2,
		STATUS_CHECKSUM = 2'd3
	} status_t;

	typedef enum logic {
		KIND_PAYLOAD = 1'b0,
		KIND_VERDICT = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t                  kind;
		logic [ByteWidth-1:0]   payload_byte;
		logic [IndexWidth-1:0]  payload_index;
		logic [ByteWidth-1:0]   addr_high;
		logic [ByteWidth-1:0]   addr_mid;
		logic [ByteWidth-1:0]   addr_low;
		status_t                status;
	} result_t;

endpackage

FILE: rtl/core/bulk_dump_frame_checker.sv
// Top level of the bulk dump frame checker.
// The slave channel takes one byte of a system-exclusive message body per
// transaction, without start and end markers; tlast marks the final byte.
// Every byte is checked against the header registers and counted. Payload
// bytes after the three address bytes are passed on the master channel with
// their index, and the final byte produces one verdict transaction that
// carries the status and the address. Other bytes produce no transaction.
// Each result is registered before it appears on the master channel.
// One byte can be taken every cycle while s_tready is high, since each byte is
// handled in a single combinational pass from frame state to output register.
// A skid register behind the output register holds one more result while the
// receiver stalls. Once it is occupied s_tready drops, and it rises again the
// cycle after the receiver takes the waiting transaction.
// The configuration port writes one register per cycle and should be used
// only while no frame is in flight.
// Reset returns the registers to their defaults and starts a new frame.
module bulk_dump_frame_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [bdfc_pkg::CfgAddrWidth-1:0] cfg_addr,
	input  logic [bdfc_pkg::RegWidth-1:0]     cfg_wdata,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [7:0]                        s_tdata,  // data_byte
	input  logic                              s_tlast,  // last_byte
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// payload_byte, payload_index, addr_high, addr_mid, addr_low, status
	output logic [47:0]                       m_tdata,
	output logic                              m_tuser   // kind
);
	import bdfc_pkg::*;

	logic    in_take;
	logic    res_valid;
	result_t res;
	result_t out_res;

	assign in_take = s_tvalid & s_tready;

	bdfc_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.in_take  (in_take),
		.in_byte  (s_tdata),
		.in_last  (s_tlast),
		.res_valid(res_valid),
		.res      (res)
	);

	bdfc_skid u_skid (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (res_valid),
		.push_data(res),
		.can_take (s_tready),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_data (out_res)
	);

	assign m_tuser = out_res.kind;
	assign m_tdata = {out_res.status, out_res.addr_low, out_res.addr_mid,
	                  out_res.addr_high, out_res.payload_index, out_res.payload_byte};

endmodule

FILE: rtl/core/bdfc_core.sv
// Frame state, configuration registers and the per-byte result logic.
module bdfc_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [bdfc_pkg::CfgAddrWidth-1:0] cfg_addr,
	input  logic [bdfc_pkg::RegWidth-1:0]     cfg_wdata,
	input  logic                              in_take,
	input  logic [bdfc_pkg::ByteWidth-1:0]    in_byte,
	input  logic                              in_last,
	output logic                              res_valid,
	output bdfc_pkg::result_t                 res
);
	import bdfc_pkg::*;

	logic [RegWidth-1:0]   manufacturer_id_q, group_high_q, group_low_q, model_id_q;
	logic [CountWidth-1:0] byte_count_q;
	logic [RegWidth-1:0]   length_high_q;
	logic [IndexWidth-1:0] frame_length_q;
	logic                  header_match_q;
	logic [RegWidth-1:0]   running_sum_q;
	logic [ByteWidth-1:0]  addr_high_q, addr_mid_q, addr_low_q;

	logic                  header_match_n;
	logic [RegWidth-1:0]   length_high_n;
	logic [IndexWidth-1:0] frame_length_n;
	logic [CountWidth-1:0] end_pos;
	logic [RegWidth-1:0]   check;
	logic [CountWidth-1:0] payload_pos;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			manufacturer_id_q <= ManufacturerIdReset;
			group_high_q      <= GroupHighReset;
			group_low_q       <= GroupLowReset;
			model_id_q        <= ModelIdReset;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_addr))
				REG_MANUFACTURER_ID: manufacturer_id_q <= cfg_wdata;
				REG_GROUP_HIGH:      group_high_q      <= cfg_wdata;
				REG_GROUP_LOW:       group_low_q       <= cfg_wdata;
				REG_MODEL_ID:        model_id_q        <= cfg_wdata;
				default:             ;
			endcase
		end
	end

	always_comb begin
		header_match_n = header_match_q;
		if (byte_count_q == PosManufacturer && in_byte != {1'b0, manufacturer_id_q})
			header_match_n = 1'b0;
		if (byte_count_q == PosGroupHigh && in_byte != {1'b0, group_high_q})
			header_match_n = 1'b0;
		if (byte_count_q == PosGroupLow && in_byte != {1'b0, group_low_q})
			header_match_n = 1'b0;
		if (byte_count_q == PosModel && in_byte != {1'b0, model_id_q})
			header_match_n = 1'b0;
		length_high_n  = (byte_count_q == PosLengthHigh) ? in_byte[RegWidth-1:0]
		                                                 : length_high_q;
		frame_length_n = (byte_count_q == PosLengthLow) ?
		                 {length_high_q, in_byte[RegWidth-1:0]} : frame_length_q;
		end_pos        = {1'b0, frame_length_n} + HeaderBytes;
		check          = RegWidth'(7'd0 - running_sum_q - model_id_q);
		payload_pos    = byte_count_q - PosPayload;

		res = '0;
		res_valid = 1'b0;
		if (in_last) begin
			res_valid     = 1'b1;
			res.kind      = KIND_VERDICT;
			res.addr_high = addr_high_q;
			res.addr_mid  = addr_mid_q;
			res.addr_low  = addr_low_q;
			if (byte_count_q < HeaderBytes || !header_match_n)
				res.status = STATUS_FOREIGN;
			else if (byte_count_q != end_pos)
				res.status = STATUS_LENGTH;
			else if (in_byte != {1'b0, check})
				res.status = STATUS_CHECKSUM;
			else
				res.status = STATUS_OK;
		end else if (byte_count_q >= PosPayload && header_match_n && byte_count_q < end_pos) begin
			res_valid         = 1'b1;
			res.kind          = KIND_PAYLOAD;
			res.payload_byte  = in_byte;
			res.payload_index = payload_pos[IndexWidth-1:0];
		end
		res_valid = res_valid & in_take;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q   <= '0;
			length_high_q  <= '0;
			frame_length_q <= '0;
			header_match_q <= 1'b1;
			running_sum_q  <= '0;
			addr_high_q    <= '0;
			addr_mid_q     <= '0;
			addr_low_q     <= '0;
		end else if (in_take) begin
			if (in_last) begin
				byte_count_q   <= '0;
				length_high_q  <= '0;
				frame_length_q <= '0;
				header_match_q <= 1'b1;
				running_sum_q  <= '0;
				addr_high_q    <= '0;
				addr_mid_q     <= '0;
				addr_low_q     <= '0;
			end else begin
				length_high_q  <= length_high_n;
				frame_length_q <= frame_length_n;
				header_match_q <= header_match_n;
				if (byte_count_q >= PosAddrHigh)
					running_sum_q <= running_sum_q + in_byte[RegWidth-1:0];
				if (byte_count_q == PosAddrHigh)
					addr_high_q <= in_byte;
				if (byte_count_q == PosAddrMid)
					addr_mid_q <= in_byte;
				if (byte_count_q == PosAddrLow)
					addr_low_q <= in_byte;
				if (byte_count_q != CountMax)
					byte_count_q <= byte_count_q + 1'b1;
			end
		end
	end

endmodule

FILE: rtl/core/bdfc_skid.sv
// Output register with a skid stage for the result channel.
module bdfc_skid (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  bdfc_pkg::result_t push_data,
	output logic              can_take,
	output logic              out_valid,
	input  logic              out_ready,
	output bdfc_pkg::result_t out_data
);
	import bdfc_pkg::*;

	logic    out_valid_q, skid_valid_q;
	result_t out_q, skid_q;
	logic    pop;

	assign pop       = out_valid_q & out_ready;
	assign can_take  = ~skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (pop || !out_valid_q)
				out_valid_q <= skid_valid_q | push;
			if (pop)
				skid_valid_q <= 1'b0;
			else if (out_valid_q && push)
				skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop || !out_valid_q)
			out_q <= skid_valid_q ? skid_q : push_data;
		if (!pop && out_valid_q && push)
			skid_q <= push_data;
	end

endmodule
